// ----- sv/xzis_pkg.sv -----
// Package with the shared types and constants of the XZ index size summer.
package xzis_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 9;
  localparam int VARINT_W = 63;
  localparam int TOTAL_W = 64;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_COUNT  = 3'd1,
    PH_UNPAD  = 3'd2,
    PH_UNCOMP = 3'd3
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] index_byte;
    logic       first_byte;
  } stage_t;

endpackage

// ----- sv/xzis_in_if.sv -----
// Input channel interface carrying one index byte per beat.
interface xzis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] index_byte;
  logic       first_byte;

  modport source (output valid, output index_byte, output first_byte, input ready);
  modport sink (input valid, input index_byte, input first_byte, output ready);
endinterface

// ----- sv/xzis_out_if.sv -----
// Result channel interface carrying the running total and status per beat.
interface xzis_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] total_size;
  logic        done_res;
  logic        error;

  modport source (output valid, output total_size, output done_res, output error,
                  input ready);
  modport sink (input valid, input total_size, input done_res, input error,
                output ready);
endinterface

// ----- sv/xzis_in_stage.sv -----
// Input register stage that captures one byte beat and hands it to the parser.
module xzis_in_stage
  import xzis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  xzis_in_if.sink    bytes,
  input  logic       take,
  output stage_t     stage
);

  assign bytes.ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
    if (bytes.valid && bytes.ready) begin
      stage.index_byte <= bytes.index_byte;
      stage.first_byte <= bytes.first_byte;
    end
  end

endmodule

// ----- sv/xzis_parser.sv -----
// Parser state, varint collector and result register of the index size summer.
module xzis_parser
  import xzis_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  stage_t     stage,
  output logic       take,
  xzis_out_if.source results
);

  localparam int CW = $clog2(MAX_VARINT_BYTES + 1);

  phase_t              phase, phase_next;
  logic [VARINT_W-1:0] varint_value, varint_value_next;
  logic [CW-1:0]       varint_bytes, varint_bytes_next;
  logic [VARINT_W-1:0] records_left, records_left_next;
  logic [TOTAL_W-1:0]  running_total, running_total_next;
  logic                error_seen, error_seen_next;

  logic [5:0]          shamt;
  logic [VARINT_W-1:0] collected;
  logic [VARINT_W-1:0] records_dec;
  logic [CW-1:0]       bytes_inc;
  logic                active, active_next, zero_err, over_err;

  assign take = stage.valid && (!results.valid || results.ready);

  assign shamt       = 6'(varint_bytes) * 6'd7;
  assign collected   = varint_value | (VARINT_W'(stage.index_byte[6:0]) << shamt);
  assign bytes_inc   = varint_bytes + CW'(1);
  assign records_dec = records_left - VARINT_W'(1);
  assign zero_err    = (varint_bytes != '0) && (stage.index_byte == 8'h00);
  assign over_err    = stage.index_byte[7] && (32'(bytes_inc) >= MAX_VARINT_BYTES);
  assign active      = (phase == PH_COUNT) || (phase == PH_UNPAD) || (phase == PH_UNCOMP);
  assign active_next = (phase_next == PH_COUNT) || (phase_next == PH_UNPAD) ||
                       (phase_next == PH_UNCOMP);

  always_comb begin
    phase_next         = phase;
    varint_value_next  = varint_value;
    varint_bytes_next  = varint_bytes;
    records_left_next  = records_left;
    running_total_next = running_total;
    error_seen_next    = error_seen;
    if (stage.first_byte) begin
      running_total_next = '0;
      records_left_next  = '0;
      varint_value_next  = '0;
      varint_bytes_next  = '0;
      error_seen_next    = (stage.index_byte != 8'h00);
      phase_next         = (stage.index_byte != 8'h00) ? PH_DONE : PH_COUNT;
    end else if (active) begin
      if (zero_err || over_err) begin
        phase_next        = PH_DONE;
        error_seen_next   = 1'b1;
        varint_value_next = '0;
        varint_bytes_next = '0;
      end else if (stage.index_byte[7]) begin
        varint_value_next = collected;
        varint_bytes_next = bytes_inc;
      end else begin
        varint_value_next = '0;
        varint_bytes_next = '0;
        unique case (phase)
          PH_COUNT: begin
            records_left_next = collected;
            phase_next = (collected == '0) ? PH_DONE : PH_UNPAD;
          end
          PH_UNPAD: begin
            phase_next = PH_UNCOMP;
          end
          PH_UNCOMP: begin
            running_total_next = running_total + {1'b0, collected};
            records_left_next  = records_dec;
            phase_next = (records_dec == '0) ? PH_DONE : PH_UNPAD;
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end else begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      varint_value  <= '0;
      varint_bytes  <= '0;
      records_left  <= '0;
      running_total <= '0;
      error_seen    <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        varint_value  <= varint_value_next;
        varint_bytes  <= varint_bytes_next;
        records_left  <= records_left_next;
        running_total <= running_total_next;
        error_seen    <= error_seen_next;
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
    if (take) begin
      results.total_size <= running_total_next;
      results.done_res   <= !active_next;
      results.error      <= error_seen_next;
    end
  end

endmodule

// ----- sv/xz_index_size_summer.sv -----
// Top level of the XZ index size summer with its input stage, parser and checks.
// The block takes one index byte per beat and gives one result beat per byte, with the
// running total of uncompressed sizes, a done flag and an error flag. It accepts a byte in
// every cycle while result beats are taken. A byte is first captured in the input register,
// and the parser writes its result into the result register when it takes the byte from
// there, which it can do only while the result register is empty or its beat is taken.
// A result that is held waits in the result register and one more byte can wait in the
// input register. The rate is set by the parser loop, where the varint shift-and-merge
// and the 64-bit total add sit between the parser state registers.
module xz_index_size_summer
  import xzis_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  xzis_in_if.sink    bytes,
  xzis_out_if.source results
);

  stage_t stage;
  logic   take;

  xzis_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .take  (take),
    .stage (stage)
  );

  xzis_parser #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .take    (take),
    .results (results)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> bytes.ready)
    else $error("Input not ready while the result register is empty.");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready) |=> stage.valid)
    else $error("Accepted beat did not reach the input register.");

  a_error_means_done: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.error) |-> results.done_res)
    else $error("Error reported while parsing is still running.");

endmodule
